/* rtl/core/iaw_pkg.sv */
// Package with the shared types and constants of the inactivity alarm watchdog.
package iaw_pkg;

    localparam int DISTANCE_BITS = 16;
    localparam int TIME_BITS     = 32;
    localparam int THRESH_BITS   = 16;
    localparam int LIMIT_BITS    = 32;
    localparam int DIVIDER_BITS  = 8;
    localparam int CHANGE_BITS   = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [THRESH_BITS-1:0]  DIFF_THRESHOLD_RESET = THRESH_BITS'(50);
    localparam logic [LIMIT_BITS-1:0]   STILL_LIMIT_RESET    = LIMIT_BITS'(10000);
    localparam logic [DIVIDER_BITS-1:0] SAMPLE_DIVIDER_RESET = DIVIDER_BITS'(4);

    // Two changes above the threshold restart the stillness timer.
    localparam logic [CHANGE_BITS-1:0]  CHANGES_FOR_MOVEMENT = CHANGE_BITS'(2);

    localparam logic [CFG_IDX_BITS-1:0] REG_DIFF_THRESHOLD = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_STILL_LIMIT    = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_DIVIDER = CFG_IDX_BITS'(2);

    typedef struct packed {
        logic [DISTANCE_BITS-1:0] distance;
        logic [TIME_BITS-1:0]     now_ms;
        logic                     alarm_request;
        logic                     alarm_stop;
    } in_item_t;

    typedef struct packed {
        logic alarm_active;
        logic alarm_notice;
        logic movement_seen;
        logic still_timeout;
    } out_item_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0]  diff_threshold;
        logic [LIMIT_BITS-1:0]   still_limit_ms;
        logic [DIVIDER_BITS-1:0] sample_divider;
    } cfg_t;

endpackage

/* rtl/core/inactivity_alarm_watchdog.sv */
// Inactivity alarm watchdog: input register, tick logic and output register.
//
// Each request on the input channel (in_valid/in_ready/in_data) is one task tick
// carrying a distance sample, a millisecond timestamp and the alarm request and
// stop buttons. Every tick yields exactly one result on the output channel
// (out_valid/out_ready/out_data): the alarm flag and the notice, movement and
// timeout events of that tick.
// A tick is registered on entry, processed against the watchdog state once the
// output register is free or being read, and its result lands in the output
// register. One tick is accepted per cycle while the receiver takes results, as
// the state update between the two registers is combinational.
// When the receiver stalls, the output register holds its result and the input
// register holds one further tick; in_ready falls only when both are occupied.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; writes to an unknown index are ignored and writes are meant for idle.
// Reset clears the state to zero with the block armed, restores the registers
// to a threshold of 50 mm, a stillness limit of 10000 ms and a divider of 4,
// and empties both pipeline registers.
module inactivity_alarm_watchdog
    import iaw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_item_t                out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    iaw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iaw_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .enable (advance),
        .item   (in_data_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule

/* rtl/core/iaw_cfg.sv */
// Configuration register file of the inactivity alarm watchdog.
module iaw_cfg
    import iaw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DIFF_THRESHOLD: cfg_next.diff_threshold = cfg_data[THRESH_BITS-1:0];
                REG_STILL_LIMIT:    cfg_next.still_limit_ms = cfg_data[LIMIT_BITS-1:0];
                REG_SAMPLE_DIVIDER: cfg_next.sample_divider = cfg_data[DIVIDER_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diff_threshold <= DIFF_THRESHOLD_RESET;
            cfg_reg.still_limit_ms <= STILL_LIMIT_RESET;
            cfg_reg.sample_divider <= SAMPLE_DIVIDER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/iaw_step.sv */
// Watchdog state and the per-tick update logic.
module iaw_step
    import iaw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      enable,
    input  in_item_t  item,
    output out_item_t result
);

    logic [DIVIDER_BITS-1:0]  sample_count_reg,  sample_count_next;
    logic [DISTANCE_BITS-1:0] prev_dist_reg,     prev_dist_next;
    logic [DISTANCE_BITS-1:0] cur_dist_reg,      cur_dist_next;
    logic [CHANGE_BITS-1:0]   change_count_reg,  change_count_next;
    logic [TIME_BITS-1:0]     still_start_reg,   still_start_next;
    logic                     alarm_reg,         alarm_next;
    logic                     armed_reg,         armed_next;

    logic [DISTANCE_BITS-1:0] delta;
    logic [TIME_BITS-1:0]     elapsed;
    logic [CHANGE_BITS-1:0]   change_inc;
    logic                     notice;
    logic                     moved;
    logic                     timeout;

    // The new sample is compared with the one taken at the previous check.
    assign delta = (item.distance >= cur_dist_reg) ? item.distance - cur_dist_reg
                                                   : cur_dist_reg - item.distance;
    assign elapsed    = item.now_ms - still_start_reg;
    assign change_inc = change_count_reg + CHANGE_BITS'(1);

    always_comb
    begin
        sample_count_next = sample_count_reg;
        prev_dist_next    = prev_dist_reg;
        cur_dist_next     = cur_dist_reg;
        change_count_next = change_count_reg;
        still_start_next  = still_start_reg;
        alarm_next        = alarm_reg;
        armed_next        = armed_reg;
        notice            = 1'b0;
        moved             = 1'b0;
        timeout           = 1'b0;

        if (!alarm_reg && armed_reg)
        begin
            if (sample_count_reg != cfg.sample_divider)
            begin
                sample_count_next = sample_count_reg + DIVIDER_BITS'(1);
            end
            else
            begin
                prev_dist_next    = cur_dist_reg;
                cur_dist_next     = item.distance;
                sample_count_next = '0;
                if (delta > cfg.diff_threshold)
                begin
                    if (change_inc >= CHANGES_FOR_MOVEMENT)
                    begin
                        still_start_next  = item.now_ms;
                        change_count_next = '0;
                        moved             = 1'b1;
                    end
                    else
                    begin
                        change_count_next = change_inc;
                    end
                end
                else if (elapsed > cfg.still_limit_ms)
                begin
                    alarm_next       = 1'b1;
                    still_start_next = item.now_ms;
                    timeout          = 1'b1;
                end
            end
            if (item.alarm_request)
            begin
                alarm_next = 1'b1;
            end
        end
        else
        begin
            if (armed_reg)
            begin
                notice     = 1'b1;
                armed_next = 1'b0;
            end
            if (item.alarm_stop)
            begin
                alarm_next = 1'b0;
                armed_next = 1'b1;
            end
        end

        result.alarm_active  = alarm_next;
        result.alarm_notice  = notice;
        result.movement_seen = moved;
        result.still_timeout = timeout;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            prev_dist_reg    <= '0;
            cur_dist_reg     <= '0;
            change_count_reg <= '0;
            still_start_reg  <= '0;
            alarm_reg        <= 1'b0;
            armed_reg        <= 1'b1;
        end
        else if (enable)
        begin
            sample_count_reg <= sample_count_next;
            prev_dist_reg    <= prev_dist_next;
            cur_dist_reg     <= cur_dist_next;
            change_count_reg <= change_count_next;
            still_start_reg  <= still_start_next;
            alarm_reg        <= alarm_next;
            armed_reg        <= armed_next;
        end
    end

endmodule
